// File: src/etsc_pkg.sv
// Shared types, constants and helpers for the epoch-to-calendar converter.
// Used by etsc_ctrl, etsc_dp and the top level; depends on nothing else.
`default_nettype none

package etsc_pkg;

  // Width of the epoch count taken at the input
  localparam int unsigned EPOCH_WIDTH = 32;

  // Whole days since the base date (86400 exceeds 2^16)
  localparam int unsigned DAYS_W = EPOCH_WIDTH - 16;

  // Year counter, wide enough for the last year an epoch can reach
  localparam int unsigned YEAR_W =
    $clog2(((64'd1 << EPOCH_WIDTH) / 64'd31536000) + 64'd1972);

  // Output field widths
  localparam int unsigned YEAR_OUT_W = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned SECOND_W   = 6;

  // A day is 128 * 675 seconds: drop the low seven bits, then divide the rest
  // by 675 through a rounded-up reciprocal, exact for every count that fits
  localparam int unsigned DAY_SHIFT   = 7;
  localparam int unsigned DAY_ODD_W   = 10;
  localparam int unsigned DAY_X_W     = EPOCH_WIDTH - DAY_SHIFT;
  localparam int unsigned DAY_K       = DAY_X_W + DAY_ODD_W;
  localparam int unsigned DAY_RECIP_W = DAY_X_W + 1;
  localparam int unsigned DAY_PROD_W  = DAY_X_W + DAY_RECIP_W;
  localparam logic [DAY_ODD_W-1:0]   DAY_ODD   = 10'd675;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
    DAY_RECIP_W'(((64'd1 << DAY_K) + 64'd674) / 64'd675);

  // Second of day and minute of day
  localparam int unsigned SOD_W = DAY_ODD_W + DAY_SHIFT;
  localparam int unsigned MOD_W = 11;

  // Division by sixty through a rounded-up reciprocal, exact for any 17-bit value
  localparam int unsigned SIXTY_K       = 23;
  localparam int unsigned SIXTY_RECIP_W = 18;
  localparam int unsigned SOD_PROD_W    = SOD_W + SIXTY_RECIP_W;
  localparam logic [SIXTY_RECIP_W-1:0] SIXTY_RECIP =
    SIXTY_RECIP_W'(((64'd1 << SIXTY_K) + 64'd59) / 64'd60);
  localparam logic [SECOND_W-1:0] SIXTY = 6'd60;

  // Calendar constants
  localparam int unsigned      BASE_YEAR    = 1970;
  localparam logic [6:0]       BASE_MOD100  = 7'd70;
  localparam logic [8:0]       BASE_MOD400  = 9'd370;
  localparam logic [6:0]       LAST_MOD100  = 7'd99;
  localparam logic [8:0]       LAST_MOD400  = 9'd399;
  localparam logic [8:0]       DAYS_COMMON  = 9'd365;
  localparam logic [8:0]       DAYS_LEAP    = 9'd366;
  localparam logic [4:0]       FEB_BASE     = 5'd28;
  localparam logic [3:0]       LAST_MONTH   = 4'd11;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_EPOCH,
    OP_DAY_DIV,
    OP_DAY_REM,
    OP_MIN_DIV,
    OP_HR_DIV,
    OP_YEAR_INIT,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINISH
  } dp_op_e;

  // Status returned to the controller
  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_status_t;

  // Length of month m (0 is January)
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd1:                      len = FEB_BASE + {4'd0, leap};
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: src/etsc_ctrl.sv
// Sequencer for the epoch-to-calendar converter: time-of-day split, year walk,
// month walk. Depends on etsc_pkg; drives etsc_dp through an operation code.
`default_nettype none

module etsc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  etsc_pkg::dp_status_t status_i,
  output etsc_pkg::dp_op_e     op_o,
  output logic                 busy_o
);
  import etsc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_YEAR  = 2'd2;
  localparam logic [1:0] ST_MONTH = 2'd3;

  localparam logic [2:0] STEP_DAY_DIV   = 3'd0;
  localparam logic [2:0] STEP_DAY_REM   = 3'd1;
  localparam logic [2:0] STEP_MIN_DIV   = 3'd2;
  localparam logic [2:0] STEP_HR_DIV    = 3'd3;
  localparam logic [2:0] STEP_YEAR_INIT = 3'd4;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  // Next state and datapath operation
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_o    = OP_LOAD_EPOCH;
          step_d  = STEP_DAY_DIV;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        unique case (step_q)
          STEP_DAY_DIV: begin
            op_o   = OP_DAY_DIV;
            step_d = STEP_DAY_REM;
          end
          STEP_DAY_REM: begin
            op_o   = OP_DAY_REM;
            step_d = STEP_MIN_DIV;
          end
          STEP_MIN_DIV: begin
            op_o   = OP_MIN_DIV;
            step_d = STEP_HR_DIV;
          end
          STEP_HR_DIV: begin
            op_o   = OP_HR_DIV;
            step_d = STEP_YEAR_INIT;
          end
          default: begin
            op_o    = OP_YEAR_INIT;
            state_d = ST_YEAR;
          end
        endcase
      end
      ST_YEAR: begin
        if (status_i.year_done) begin
          state_d = ST_MONTH;
        end else begin
          op_o = OP_YEAR_STEP;
        end
      end
      default: begin
        if (status_i.month_done) begin
          op_o    = OP_FINISH;
          state_d = ST_IDLE;
        end else begin
          op_o = OP_MONTH_STEP;
        end
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_DAY_DIV;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: src/etsc_dp.sv
// Datapath of the epoch-to-calendar converter: reciprocal constant division,
// year and month counters, result registers. Depends on etsc_pkg.
`default_nettype none

module etsc_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  etsc_pkg::dp_op_e                  op_i,
  input  wire  [etsc_pkg::EPOCH_WIDTH-1:0]  epoch_seconds_i,
  output etsc_pkg::dp_status_t              status_o,
  output logic                              done_o,
  output logic [etsc_pkg::YEAR_OUT_W-1:0]   year_o,
  output logic [etsc_pkg::MONTH_W-1:0]      month_o,
  output logic [etsc_pkg::DAY_W-1:0]        day_of_month_o,
  output logic [etsc_pkg::HOUR_W-1:0]       hour_o,
  output logic [etsc_pkg::MINUTE_W-1:0]     minute_o,
  output logic [etsc_pkg::SECOND_W-1:0]     second_o
);
  import etsc_pkg::*;

  logic [EPOCH_WIDTH-1:0] epoch_q;
  logic [DAYS_W-1:0]      days_q;
  logic [SOD_W-1:0]       sod_q;
  logic [MOD_W-1:0]       mod_q;
  logic [YEAR_W-1:0]      year_q;
  logic [6:0]             mod100_q;
  logic [8:0]             mod400_q;
  logic [3:0]             month_q;
  logic [SECOND_W-1:0]    sec_q;
  logic                   done_q;

  logic [DAYS_W-1:0] day_quot;
  logic [MOD_W-1:0]  min_quot;
  logic [HOUR_W-1:0] hour_quot;
  logic              leap;
  logic [8:0]        year_len;
  logic [4:0]        month_len;

  // Quotients by reciprocal multiplication
  assign day_quot  = DAYS_W'((DAY_PROD_W'(epoch_q[EPOCH_WIDTH-1:DAY_SHIFT]) *
                              DAY_PROD_W'(DAY_RECIP)) >> DAY_K);
  assign min_quot  = MOD_W'((SOD_PROD_W'(sod_q) * SOD_PROD_W'(SIXTY_RECIP)) >> SIXTY_K);
  assign hour_quot = HOUR_W'((SOD_PROD_W'(mod_q) * SOD_PROD_W'(SIXTY_RECIP)) >> SIXTY_K);

  // Gregorian leap rule from the running residues
  assign leap      = (year_q[1:0] == 2'b00) && ((mod100_q != '0) || (mod400_q == '0));
  assign year_len  = leap ? DAYS_LEAP : DAYS_COMMON;
  assign month_len = month_days(month_q, leap);

  assign status_o.year_done  = (days_q < DAYS_W'(year_len));
  assign status_o.month_done = (month_q == LAST_MONTH) || (days_q < DAYS_W'(month_len));

  // Work registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD_EPOCH: begin
        epoch_q <= epoch_seconds_i;
      end
      OP_DAY_DIV: begin
        days_q <= day_quot;
      end
      OP_DAY_REM: begin
        // remainder by 675 fits its low bits, then restore the dropped seconds
        sod_q <= {epoch_q[DAY_SHIFT +: DAY_ODD_W] - DAY_ODD_W'(days_q * DAY_ODD),
                  epoch_q[DAY_SHIFT-1:0]};
      end
      OP_MIN_DIV: begin
        mod_q <= min_quot;
      end
      OP_HR_DIV: begin
        sec_q  <= sod_q[SECOND_W-1:0] - SECOND_W'(mod_q * SIXTY);
        hour_o <= hour_quot;
      end
      OP_YEAR_INIT: begin
        minute_o <= mod_q[MINUTE_W-1:0] - MINUTE_W'(hour_o * SIXTY);
        year_q   <= YEAR_W'(BASE_YEAR);
        mod100_q <= BASE_MOD100;
        mod400_q <= BASE_MOD400;
        month_q  <= '0;
      end
      OP_YEAR_STEP: begin
        days_q   <= days_q - DAYS_W'(year_len);
        year_q   <= year_q + 1'b1;
        mod100_q <= (mod100_q == LAST_MOD100) ? '0 : mod100_q + 1'b1;
        mod400_q <= (mod400_q == LAST_MOD400) ? '0 : mod400_q + 1'b1;
      end
      OP_MONTH_STEP: begin
        days_q  <= days_q - DAYS_W'(month_len);
        month_q <= month_q + 1'b1;
      end
      OP_FINISH: begin
        year_o         <= year_q[YEAR_OUT_W-1:0];
        month_o        <= month_q + 1'b1;
        day_of_month_o <= days_q[DAY_W-1:0] + 1'b1;
        second_o       <= sec_q;
      end
      default: begin
      end
    endcase
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (op_i == OP_FINISH);
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// File: src/epoch_seconds_to_calendar.sv
// Top level of the epoch-to-calendar converter: controller plus datapath.
// Depends on etsc_pkg, etsc_ctrl and etsc_dp.
//
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into
// Gregorian year, month, day, hour, minute and second. Pulse start while busy
// is low to hand over an item; busy stays high until the result appears.
// The result is shown for exactly one cycle with done_o high and is not held
// afterwards, so the receiver must take it in that cycle. The conversion loads
// the epoch, splits off days, seconds, minutes and hours by reciprocal
// multiplication, sets up the year counter, walks it year by year, switches
// to the month counter, walks it month by month after January and registers
// the result. With a 32-bit epoch the longest conversion is for December 2105.
// A new item may start in the cycle the previous result is shown.
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [etsc_pkg::EPOCH_WIDTH-1:0]  epoch_seconds_i,
  output logic                              done_o,
  output logic [etsc_pkg::YEAR_OUT_W-1:0]   year_o,
  output logic [etsc_pkg::MONTH_W-1:0]      month_o,
  output logic [etsc_pkg::DAY_W-1:0]        day_of_month_o,
  output logic [etsc_pkg::HOUR_W-1:0]       hour_o,
  output logic [etsc_pkg::MINUTE_W-1:0]     minute_o,
  output logic [etsc_pkg::SECOND_W-1:0]     second_o
);
  import etsc_pkg::*;

  dp_op_e     op;
  dp_status_t status;

  // Sequencer
  etsc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy)
  );

  // Arithmetic and result registers
  etsc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .epoch_seconds_i (epoch_seconds_i),
    .status_o        (status),
    .done_o          (done_o),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o)
  );

endmodule

`default_nettype wire
